>>> sv/mma_pkg.sv
// shared types and constants for the matrix multiply-accumulate block
// no dependencies; every other file refers to this package by scoped names
package mma_pkg;

    localparam int MATRIX_DIM = 3;
    localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
    localparam int LOAD_TOTAL = 2 * CELLS;
    localparam int WORD_W     = 32;

    localparam int DIM_W  = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
    localparam int CIDX_W = $clog2(CELLS);
    localparam int LOAD_W = $clog2(LOAD_TOTAL);

    // command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // result queue at the output
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [CIDX_W-1:0]   cidx_t;
    typedef logic [LOAD_W-1:0]   load_t;
    typedef logic [CQ_PTR_W-1:0] cq_ptr_t;
    typedef logic [CQ_CNT_W-1:0] cq_cnt_t;
    typedef logic [RQ_PTR_W-1:0] rq_ptr_t;
    typedef logic [RQ_CNT_W-1:0] rq_cnt_t;

    // one classified element on its way to the back end
    typedef struct packed {
        logic  is_b;
        logic  last;
        cidx_t addr;
        word_t value;
    } load_cmd_t;

    // one result element
    typedef struct packed {
        word_t value;
        logic  last;
    } res_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_MAC,
        BK_DRAIN,
        BK_EMIT
    } back_state_t;

endpackage

>>> sv/mma_front.sv
// front end: counts incoming elements and tags each as an A or B entry
// depends on mma_pkg
module mma_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mma_pkg::word_t     element,
    input  logic               cmd_full,
    output logic               full,
    output logic               cmd_push,
    output mma_pkg::load_cmd_t cmd
);

    mma_pkg::load_t pos_reg;
    mma_pkg::load_t pos_next;
    logic           in_take;

    assign full    = cmd_full;
    assign in_take = push && !cmd_full;
    assign cmd_push = in_take;

    // classify by position in the run
    always_comb
    begin
        cmd.value = element;
        cmd.is_b  = (pos_reg >= mma_pkg::load_t'(mma_pkg::CELLS));
        cmd.last  = (pos_reg == mma_pkg::load_t'(mma_pkg::LOAD_TOTAL - 1));
        if (cmd.is_b)
        begin
            cmd.addr = mma_pkg::cidx_t'(pos_reg - mma_pkg::load_t'(mma_pkg::CELLS));
        end
        else
        begin
            cmd.addr = mma_pkg::cidx_t'(pos_reg);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (in_take)
        begin
            if (cmd.last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + mma_pkg::load_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> sv/mma_cmd_queue.sv
// short queue of classified load commands between front and back end
// depends on mma_pkg
module mma_cmd_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  mma_pkg::load_cmd_t wr_data,
    input  logic               rd_en,
    output logic               full,
    output logic               valid,
    output mma_pkg::load_cmd_t rd_data
);

    mma_pkg::load_cmd_t slot_reg [mma_pkg::CQ_DEPTH];
    mma_pkg::cq_ptr_t   wr_ptr_reg;
    mma_pkg::cq_ptr_t   wr_ptr_next;
    mma_pkg::cq_ptr_t   rd_ptr_reg;
    mma_pkg::cq_ptr_t   rd_ptr_next;
    mma_pkg::cq_cnt_t   count_reg;
    mma_pkg::cq_cnt_t   count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == mma_pkg::cq_cnt_t'(mma_pkg::CQ_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == mma_pkg::cq_ptr_t'(mma_pkg::CQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + mma_pkg::cq_ptr_t'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == mma_pkg::cq_ptr_t'(mma_pkg::CQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + mma_pkg::cq_ptr_t'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + mma_pkg::cq_cnt_t'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - mma_pkg::cq_cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/mma_back.sv
// back end: holds A, B and the accumulator C, runs the multiply-accumulate
// and streams C out; depends on mma_pkg
module mma_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  mma_pkg::load_cmd_t cmd,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output mma_pkg::res_t      res
);

    mma_pkg::back_state_t state_reg;
    mma_pkg::back_state_t state_next;

    mma_pkg::word_t a_store_reg [mma_pkg::CELLS];
    mma_pkg::word_t b_store_reg [mma_pkg::CELLS];
    mma_pkg::word_t c_acc_reg   [mma_pkg::CELLS];

    mma_pkg::dim_t  i_reg;
    mma_pkg::dim_t  j_reg;
    mma_pkg::dim_t  k_reg;
    mma_pkg::cidx_t emit_idx_reg;

    logic           s1_valid_reg;
    logic           s2_valid_reg;
    mma_pkg::cidx_t s1_cidx_reg;
    mma_pkg::cidx_t s2_cidx_reg;
    mma_pkg::word_t a_rd_reg;
    mma_pkg::word_t b_rd_reg;
    mma_pkg::word_t prod_reg;

    logic           issue;
    logic           last_ijk;
    logic           last_emit;
    mma_pkg::cidx_t a_addr;
    mma_pkg::cidx_t b_addr;
    mma_pkg::cidx_t c_addr;
    mma_pkg::cidx_t c_rd_addr;
    mma_pkg::word_t c_rd;

    localparam mma_pkg::dim_t DIM_MAX = mma_pkg::dim_t'(mma_pkg::MATRIX_DIM - 1);

    assign last_ijk  = (i_reg == DIM_MAX) && (j_reg == DIM_MAX) && (k_reg == DIM_MAX);
    assign last_emit = (emit_idx_reg == mma_pkg::cidx_t'(mma_pkg::CELLS - 1));

    assign a_addr = mma_pkg::cidx_t'(i_reg * mma_pkg::MATRIX_DIM + j_reg);
    assign b_addr = mma_pkg::cidx_t'(j_reg * mma_pkg::MATRIX_DIM + k_reg);
    assign c_addr = mma_pkg::cidx_t'(i_reg * mma_pkg::MATRIX_DIM + k_reg);

    // accumulate and emit never overlap, so C has one read port
    assign c_rd_addr = (state_reg == mma_pkg::BK_EMIT) ? emit_idx_reg : s2_cidx_reg;
    assign c_rd      = c_acc_reg[c_rd_addr];

    assign res = {c_rd, last_emit};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mma_pkg::BK_LOAD:
            begin
                if (cmd_valid && cmd.last)
                begin
                    state_next = mma_pkg::BK_MAC;
                end
            end
            mma_pkg::BK_MAC:
            begin
                if (last_ijk)
                begin
                    state_next = mma_pkg::BK_DRAIN;
                end
            end
            mma_pkg::BK_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = mma_pkg::BK_EMIT;
                end
            end
            mma_pkg::BK_EMIT:
            begin
                if (!res_full && last_emit)
                begin
                    state_next = mma_pkg::BK_LOAD;
                end
            end
            default:
            begin
                state_next = mma_pkg::BK_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        issue    = 1'b0;
        res_push = 1'b0;
        case (state_reg)
            mma_pkg::BK_LOAD:  cmd_pop  = cmd_valid;
            mma_pkg::BK_MAC:   issue    = 1'b1;
            mma_pkg::BK_EMIT:  res_push = !res_full;
            default:           cmd_pop  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mma_pkg::BK_LOAD;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            emit_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            // i outer, j middle, k inner
            if (issue)
            begin
                if (k_reg == DIM_MAX)
                begin
                    k_reg <= '0;
                    if (j_reg == DIM_MAX)
                    begin
                        j_reg <= '0;
                        i_reg <= (i_reg == DIM_MAX) ? '0 : i_reg + mma_pkg::dim_t'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + mma_pkg::dim_t'(1);
                    end
                end
                else
                begin
                    k_reg <= k_reg + mma_pkg::dim_t'(1);
                end
            end
            if (res_push)
            begin
                emit_idx_reg <= last_emit ? '0 : emit_idx_reg + mma_pkg::cidx_t'(1);
            end
        end
    end

    // operand stores, registered reads and the multiplier stage
    always_ff @(posedge clk)
    begin
        if (cmd_pop && !cmd.is_b)
        begin
            a_store_reg[cmd.addr] <= cmd.value;
        end
        if (cmd_pop && cmd.is_b)
        begin
            b_store_reg[cmd.addr] <= cmd.value;
        end
        a_rd_reg    <= a_store_reg[a_addr];
        b_rd_reg    <= b_store_reg[b_addr];
        s1_cidx_reg <= c_addr;
        prod_reg    <= a_rd_reg * b_rd_reg;
        s2_cidx_reg <= s1_cidx_reg;
    end

    // accumulator, wraps at 32 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < mma_pkg::CELLS; n++)
            begin
                c_acc_reg[n] <= '0;
            end
        end
        else if (s2_valid_reg)
        begin
            c_acc_reg[s2_cidx_reg] <= c_rd + prod_reg;
        end
    end

endmodule

>>> sv/mma_result_queue.sv
// output queue of result elements, shown first-word-fall-through
// depends on mma_pkg
module mma_result_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mma_pkg::res_t wr_data,
    input  logic          rd_en,
    output logic          full,
    output logic          empty,
    output mma_pkg::res_t rd_data
);

    mma_pkg::res_t   slot_reg [mma_pkg::RQ_DEPTH];
    mma_pkg::rq_ptr_t wr_ptr_reg;
    mma_pkg::rq_ptr_t wr_ptr_next;
    mma_pkg::rq_ptr_t rd_ptr_reg;
    mma_pkg::rq_ptr_t rd_ptr_next;
    mma_pkg::rq_cnt_t count_reg;
    mma_pkg::rq_cnt_t count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == mma_pkg::rq_cnt_t'(mma_pkg::RQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == mma_pkg::rq_ptr_t'(mma_pkg::RQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + mma_pkg::rq_ptr_t'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == mma_pkg::rq_ptr_t'(mma_pkg::RQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + mma_pkg::rq_ptr_t'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + mma_pkg::rq_cnt_t'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - mma_pkg::rq_cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/matrix_multiply_accumulate.sv
// first element of C follows the last B transaction after the N^3 multiply-accumulate
// steps of the single multiplier, then a 3-stage pipe (operand read, multiply, accumulate)
// a run of 2*N^2 elements is loaded first; loads go at one per cycle while the command queue
// holds one, then one multiply-accumulate per cycle; the next run's loads wait there until C is emitted
// reset: asynchronous, active low; clears C, the load position and both queues
// A and B hold no reset value and are always fully written before use
module matrix_multiply_accumulate
(
    input  logic               clk,
    input  logic               rst_n,
    // element stream, A then B, row-major
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] element,
    // result stream, C row-major
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] product_element,
    output logic               last_element
);

    // front to command queue
    logic               fr_push;
    mma_pkg::load_cmd_t fr_cmd;
    logic               cq_full;

    // command queue to back end
    logic               cq_valid;
    mma_pkg::load_cmd_t cq_cmd;
    logic               bk_pop;

    // back end to result queue
    logic               rq_full;
    logic               bk_res_push;
    mma_pkg::res_t      bk_res;
    mma_pkg::res_t      rq_res;

    // front end: element counter and A/B classification
    mma_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .element  (mma_pkg::word_t'(element)),
        .cmd_full (cq_full),
        .full     (full),
        .cmd_push (fr_push),
        .cmd      (fr_cmd)
    );

    // decouples input transactions from the multiply-accumulate run
    mma_cmd_queue u_cmd_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_push),
        .wr_data (fr_cmd),
        .rd_en   (bk_pop),
        .full    (cq_full),
        .valid   (cq_valid),
        .rd_data (cq_cmd)
    );

    // back end: operand stores, multiplier pipe, accumulator, emit sequencer
    mma_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cq_valid),
        .cmd       (cq_cmd),
        .cmd_pop   (bk_pop),
        .res_full  (rq_full),
        .res_push  (bk_res_push),
        .res       (bk_res)
    );

    // two-entry output queue between the emit sequencer and the consumer;
    // a consumer stalled longer than that holds the emit sequencer
    mma_result_queue u_result_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bk_res_push),
        .wr_data (bk_res),
        .rd_en   (pop),
        .full    (rq_full),
        .empty   (empty),
        .rd_data (rq_res)
    );

    assign product_element = signed'(rq_res.value);
    assign last_element    = rq_res.last;

endmodule

>>> sv/mma_checker.sv
// port-level checker for matrix_multiply_accumulate, bound to the top level
// depends on mma_pkg
module mma_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] product_element,
    input logic               last_element
);

    mma_pkg::load_t in_cnt_reg;
    mma_pkg::cidx_t out_cnt_reg;
    logic [2:0]     runs_pending_reg;
    logic           in_take;
    logic           out_take;
    logic           run_done;
    logic           run_out;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;
    assign run_done = in_take && (in_cnt_reg == mma_pkg::load_t'(mma_pkg::LOAD_TOTAL - 1));
    assign run_out  = out_take && last_element;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg       <= '0;
            out_cnt_reg      <= '0;
            runs_pending_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_cnt_reg <= run_done ? '0 : in_cnt_reg + mma_pkg::load_t'(1);
            end
            if (out_take)
            begin
                out_cnt_reg <= (out_cnt_reg == mma_pkg::cidx_t'(mma_pkg::CELLS - 1)) ?
                               '0 : out_cnt_reg + mma_pkg::cidx_t'(1);
            end
            runs_pending_reg <= runs_pending_reg + {2'b00, run_done} - {2'b00, run_out};
        end
    end

    // nothing to show while in reset
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result visible during reset");

    // last flag marks exactly every N^2-th result transaction
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (last_element == (out_cnt_reg == mma_pkg::cidx_t'(mma_pkg::CELLS - 1))))
        else $error("last_element on wrong result position");

    // results only follow a completed load of A and B
    a_result_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (runs_pending_reg != '0))
        else $error("result without a completed load");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(product_element) && $stable(last_element)))
        else $error("waiting result changed");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .product_element (product_element),
    .last_element    (last_element)
);

>>> tb/tb_top.sv
// self-checking testbench for matrix_multiply_accumulate: streams A/B matrix pairs,
// predicts the accumulated C matrix and checks every emitted element and its last flag
// depends on mma_pkg (dimensions, word and result types) and the block's rtl
module tb_top;

    // run shape
    localparam int DIRECTED_SETS = 1;
    localparam int RANDOM_SETS   = 16;
    localparam int TOTAL_SETS    = DIRECTED_SETS + RANDOM_SETS;
    localparam int IDLE_PCT      = 26;
    localparam int HOLD_CYCLES   = 400;
    // tail after the last expected result: one full multiply pass plus slack
    localparam int TAIL_CYCLES   =
        2 * (mma_pkg::MATRIX_DIM * mma_pkg::MATRIX_DIM * mma_pkg::MATRIX_DIM + 10);
    // this limit leaves lots of room over the worst case
    localparam int CYCLE_LIMIT   = 100000;

    // keeps its own copy of A, B and the running C; one expected entry per C element
    class mma_scoreboard;
        mma_pkg::word_t a_store [mma_pkg::CELLS];
        mma_pkg::word_t b_store [mma_pkg::CELLS];
        mma_pkg::word_t c_acc   [mma_pkg::CELLS];
        int unsigned    load_pos;
        mma_pkg::res_t  expected_q [$];
        int unsigned    errors;
        int unsigned    elements_in;
        int unsigned    products_done;
        int unsigned    results_checked;

        function new();
            foreach (c_acc[n])
            begin
                a_store[n] = '0;
                b_store[n] = '0;
                c_acc[n]   = '0;
            end
            load_pos        = 0;
            errors          = 0;
            elements_in     = 0;
            products_done   = 0;
            results_checked = 0;
        endfunction

        // one accepted input transaction
        function void note_element(mma_pkg::word_t value);
            mma_pkg::res_t r;
            if (load_pos < mma_pkg::CELLS)
                a_store[load_pos] = value;
            else
                b_store[load_pos - mma_pkg::CELLS] = value;
            load_pos++;
            elements_in++;
            if (load_pos == mma_pkg::LOAD_TOTAL)
            begin
                load_pos = 0;
                // C += A * B, every product and sum wraps at 32 bits
                for (int i = 0; i < mma_pkg::MATRIX_DIM; i++)
                    for (int j = 0; j < mma_pkg::MATRIX_DIM; j++)
                        for (int k = 0; k < mma_pkg::MATRIX_DIM; k++)
                            c_acc[i*mma_pkg::MATRIX_DIM + k] = c_acc[i*mma_pkg::MATRIX_DIM + k]
                                + a_store[i*mma_pkg::MATRIX_DIM + j]
                                * b_store[j*mma_pkg::MATRIX_DIM + k];
                for (int n = 0; n < mma_pkg::CELLS; n++)
                begin
                    r.value = c_acc[n];
                    r.last  = (n == mma_pkg::CELLS - 1);
                    expected_q.push_back(r);
                end
                products_done++;
            end
        endfunction

        // one accepted result transaction
        function void check_result(mma_pkg::word_t value, logic last);
            mma_pkg::res_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: product_element %h last_element %b",
                       value, last);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            if (value !== exp_r.value)
            begin
                $error("product_element: expected %h, actual %h", exp_r.value, value);
                errors++;
            end
            if (last !== exp_r.last)
            begin
                $error("last_element: expected %b, actual %b", exp_r.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] element;
    logic               empty;
    logic               pop;
    logic signed [31:0] product_element;
    logic               last_element;

    // steady: neither side idles; hold_request: receiver goes quiet for a long stretch
    logic               steady;
    logic               hold_request;
    int unsigned        cycle_count;

    mma_scoreboard      sb;

    matrix_multiply_accumulate dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .element         (element),
        .empty           (empty),
        .pop             (pop),
        .product_element (product_element),
        .last_element    (last_element)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog, counts every clock from time zero
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // mostly full-range words, with small values and the corner words mixed in
    function automatic mma_pkg::word_t pick_element();
        int unsigned    sel;
        mma_pkg::word_t corners [6];
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'h0000_0001, 32'h0001_0000};
        sel = $urandom_range(99);
        if (sel < 55)
            return mma_pkg::word_t'($urandom);
        else if (sel < 80)
            return mma_pkg::word_t'(int'($urandom_range(16)) - 8);
        else
            return corners[$urandom_range(5)];
    endfunction

    // one input transaction, with random idle cycles in front of it
    task automatic send_element(mma_pkg::word_t value);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        element <= value;
        // full is sampled as it was just before the edge, so this is the accept condition
        do
            @(posedge clk);
        while (full);
        sb.note_element(value);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random pop, a long hold on request, check on every accepted result
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pop <= 1'b0;
                // counted here so the sender keeps pushing until the block backs up
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(product_element, last_element);
        end
    end

    // main sequence
    initial
    begin
        mma_pkg::word_t a_corner [mma_pkg::CELLS];
        mma_pkg::word_t b_corner [mma_pkg::CELLS];

        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        element      = '0;
        steady       = 1'b0;
        hold_request = 1'b0;

        // extremes, sign changes and products that wrap at 32 bits
        a_corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};
        b_corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0001_0000, 32'h0000_0003, 32'hFFFF_FFFE};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed set: corner words, C starts from zero
        for (int n = 0; n < mma_pkg::CELLS; n++)
            send_element(a_corner[n]);
        for (int n = 0; n < mma_pkg::CELLS; n++)
            send_element(b_corner[n]);

        // random sets; C keeps accumulating across all of them
        for (int s = DIRECTED_SETS; s < TOTAL_SETS; s++)
        begin
            // a stretch of back-to-back traffic on both sides
            steady = (s >= 4 && s < 8);
            // receiver goes quiet while this set and the next are offered
            if (s == 11)
                hold_request = 1'b1;
            // sender waits for the block to drain completely before this set
            if (s == 14)
            begin
                push <= 1'b0;
                wait_drained();
            end
            for (int n = 0; n < mma_pkg::LOAD_TOTAL; n++)
                send_element(pick_element());
        end
        steady = 1'b0;
        push <= 1'b0;

        wait_drained();
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d element transactions, %0d accumulated products, %0d checked",
                 sb.elements_in, sb.products_done, sb.results_checked);
        $display("including corner words, wrap-around, back-pressure and a full drain");
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
